FILE: rtl/homography_truncated_residual_macros.svh
// assertion macros for the homography residual block
`ifndef HOMOGRAPHY_TRUNCATED_RESIDUAL_MACROS_SVH
`define HOMOGRAPHY_TRUNCATED_RESIDUAL_MACROS_SVH

// condition implies consequence in the same cycle
`define HTR_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence a fixed number of cycles later
`define HTR_ASSERT_DELAY(label, clk, rst, cond, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##n (cons)) \
    else $error(msg);

`endif

FILE: rtl/htr_pkg.sv
// shared types, constants and helpers for the homography residual block
`timescale 1ns / 1ps
package htr_pkg;

  localparam int COEF_W = 21;
  localparam int COORD_W = 16;
  localparam int ROW_W = 3 * COEF_W;
  localparam int PROD_W = COEF_W + COORD_W + 1;
  localparam int NUM_W = 39;
  localparam int MAG_W = NUM_W - 1;
  localparam int RES_W = 32;
  localparam int RES_FRAC_BITS = 8;
  localparam int ERR_W = 32;
  localparam int SQ_W = 2 * ERR_W;
  localparam int CFG_IDX_W = 3;
  localparam int DEF_COORD_FRAC_BITS = 4;

  localparam logic [ROW_W-1:0] ROW0_RESET = ROW_W'(64'd65536);
  localparam logic [ROW_W-1:0] ROW1_RESET = ROW_W'(64'd137438953472);
  localparam logic [ROW_W-1:0] ROW2_RESET = ROW_W'(64'd288230376151711744);
  localparam logic [RES_W-1:0] THRESHOLD_RESET = RES_W'(6400);
  localparam logic [RES_W-1:0] RES_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF_ROW0 = 3'd0,
    REG_COEFF_ROW1 = 3'd1,
    REG_COEFF_ROW2 = 3'd2,
    REG_CLAMP_THRESHOLD = 3'd3,
    REG_TRUNCATE_ENABLE = 3'd4
  } reg_idx_t;

  // control that travels alongside a point match
  typedef struct packed {
    logic valid;
    logic degen;
  } ctl_t;

  // pick one signed coefficient out of a packed row
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [ROW_W-1:0] row,
                                                       input int unsigned col);
    coef_at = $signed(row[col*COEF_W +: COEF_W]);
  endfunction

endpackage

FILE: rtl/htr_warp.sv
// three-stage projective warp: products, row sums, magnitudes and signs
`timescale 1ns / 1ps
module htr_warp #(
  parameter int COORD_FRAC_BITS = htr_pkg::DEF_COORD_FRAC_BITS,
  parameter int QW = htr_pkg::MAG_W + COORD_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [htr_pkg::COORD_W-1:0] prev_x,
  input  logic [htr_pkg::COORD_W-1:0] prev_y,
  input  logic [htr_pkg::COORD_W-1:0] curr_x,
  input  logic [htr_pkg::COORD_W-1:0] curr_y,
  input  logic [htr_pkg::ROW_W-1:0] row0,
  input  logic [htr_pkg::ROW_W-1:0] row1,
  input  logic [htr_pkg::ROW_W-1:0] row2,
  output htr_pkg::ctl_t ctl,
  output logic neg_x,
  output logic neg_y,
  output logic [QW-1:0] dvd_x,
  output logic [QW-1:0] dvd_y,
  output logic [htr_pkg::MAG_W-1:0] dsr,
  output logic [htr_pkg::COORD_W-1:0] cur_x,
  output logic [htr_pkg::COORD_W-1:0] cur_y
);
  import htr_pkg::*;

  logic vld1, vld2;
  logic signed [PROD_W-1:0] px_p [3];
  logic signed [PROD_W-1:0] py_p [3];
  logic signed [NUM_W-1:0] c2_p [3];
  logic [COORD_W-1:0] cx1, cy1, cx2, cy2;
  logic signed [NUM_W-1:0] num0, num1, den;
  logic [MAG_W-1:0] mag0, mag1, magd;

  // stage 1: coefficient products
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      logic [ROW_W-1:0] row;
      row = (r == 0) ? row0 : ((r == 1) ? row1 : row2);
      px_p[r] <= coef_at(row, 0) * $signed({1'b0, prev_x});
      py_p[r] <= coef_at(row, 1) * $signed({1'b0, prev_y});
      c2_p[r] <= NUM_W'(coef_at(row, 2)) <<< COORD_FRAC_BITS;
    end
    cx1 <= curr_x;
    cy1 <= curr_y;
  end

  // stage 2: row sums
  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    num0 <= NUM_W'(px_p[0]) + NUM_W'(py_p[0]) + c2_p[0];
    num1 <= NUM_W'(px_p[1]) + NUM_W'(py_p[1]) + c2_p[1];
    den <= NUM_W'(px_p[2]) + NUM_W'(py_p[2]) + c2_p[2];
    cx2 <= cx1;
    cy2 <= cy1;
  end

  // magnitudes for the unsigned divider
  assign mag0 = num0[NUM_W-1] ? MAG_W'(-num0) : num0[MAG_W-1:0];
  assign mag1 = num1[NUM_W-1] ? MAG_W'(-num1) : num1[MAG_W-1:0];
  assign magd = den[NUM_W-1] ? MAG_W'(-den) : den[MAG_W-1:0];

  // stage 3: dividends, divisor, quotient signs, zero check
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    ctl.degen <= (den == '0);
    neg_x <= num0[NUM_W-1] ^ den[NUM_W-1];
    neg_y <= num1[NUM_W-1] ^ den[NUM_W-1];
    dvd_x <= QW'(mag0) << COORD_FRAC_BITS;
    dvd_y <= QW'(mag1) << COORD_FRAC_BITS;
    dsr <= magd;
    cur_x <= cx2;
    cur_y <= cy2;
  end

endmodule

FILE: rtl/htr_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module htr_div #(
  parameter int QW = htr_pkg::MAG_W + htr_pkg::DEF_COORD_FRAC_BITS,
  parameter int DB = htr_pkg::MAG_W,
  parameter int TAG_W = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [QW-1:0] dividend,
  input  logic [DB-1:0] divisor,
  input  logic [TAG_W-1:0] tag_in,
  output logic out_valid,
  output logic [QW-1:0] quotient,
  output logic [TAG_W-1:0] tag_out
);
  import htr_pkg::*;

  logic [QW-1:0] vld_q;
  logic [QW-1:0] num_q [QW];
  logic [DB-1:0] rem_q [QW];
  logic [DB-1:0] dsr_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [TAG_W-1:0] tag_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic vld_in;
    logic [QW-1:0] num_in, quo_in;
    logic [DB-1:0] rem_in, dsr_in;
    logic [TAG_W-1:0] tag_s;
    logic [DB:0] trial, diff;

    if (k == 0) begin : g_first
      assign vld_in = in_valid;
      assign num_in = dividend;
      assign quo_in = '0;
      assign rem_in = '0;
      assign dsr_in = divisor;
      assign tag_s = tag_in;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign num_in = num_q[k-1];
      assign quo_in = quo_q[k-1];
      assign rem_in = rem_q[k-1];
      assign dsr_in = dsr_q[k-1];
      assign tag_s = tag_q[k-1];
    end

    // shift in the next dividend bit and try the subtract
    assign trial = {rem_in, num_in[QW-1]};
    assign diff = trial - {1'b0, dsr_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      num_q[k] <= num_in << 1;
      rem_q[k] <= diff[DB] ? trial[DB-1:0] : diff[DB-1:0];
      quo_q[k] <= {quo_in[QW-2:0], ~diff[DB]};
      dsr_q[k] <= dsr_in;
      tag_q[k] <= tag_s;
    end
  end

  assign out_valid = vld_q[QW-1];
  assign quotient = quo_q[QW-1];
  assign tag_out = tag_q[QW-1];

endmodule

FILE: rtl/htr_score.sv
// error, square, sum and clamp stages of the residual
`timescale 1ns / 1ps
module htr_score #(
  parameter int COORD_FRAC_BITS = htr_pkg::DEF_COORD_FRAC_BITS,
  parameter int QW = htr_pkg::MAG_W + COORD_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  htr_pkg::ctl_t ctl_in,
  input  logic [QW-1:0] qx,
  input  logic [QW-1:0] qy,
  input  logic neg_x,
  input  logic neg_y,
  input  logic [htr_pkg::COORD_W-1:0] cur_x,
  input  logic [htr_pkg::COORD_W-1:0] cur_y,
  input  logic [htr_pkg::RES_W-1:0] thr,
  input  logic trunc,
  output logic done,
  output logic [htr_pkg::RES_W-1:0] residual,
  output logic clipped,
  output logic degenerate
);
  import htr_pkg::*;

  localparam int SH = 2 * COORD_FRAC_BITS - RES_FRAC_BITS;
  localparam int E_W = ERR_W + 2;
  localparam logic [E_W-1:0] ERR_LIMIT = E_W'(1) << (ERR_W - 1);

  ctl_t ctl_e, ctl_s, ctl_h;
  logic [ERR_W-1:0] ex, ey, ex_next, ey_next;
  logic [SQ_W-1:0] sx, sy, sum;
  logic [RES_W-1:0] res_h, res_sh;
  logic sat_h, sat_sh;

  // absolute error against the current point, clamped at the limit
  function automatic logic [ERR_W-1:0] clamp_err(input logic [QW-1:0] q, input logic neg,
                                                 input logic [COORD_W-1:0] cur);
    logic big;
    logic signed [E_W-1:0] qs, e;
    logic [E_W-1:0] ae;
    big = |(q >> ERR_W);
    qs = $signed(E_W'(q[ERR_W-1:0]));
    if (neg) qs = -qs;
    e = qs - $signed(E_W'(cur));
    ae = e[E_W-1] ? E_W'(-e) : E_W'(e);
    if (big || ae > ERR_LIMIT) clamp_err = ERR_LIMIT[ERR_W-1:0];
    else clamp_err = ae[ERR_W-1:0];
  endfunction

  assign ex_next = clamp_err(qx, neg_x, cur_x);
  assign ey_next = clamp_err(qy, neg_y, cur_y);

  // valid bits down the score stages
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_e.valid <= 1'b0;
      ctl_s.valid <= 1'b0;
      ctl_h.valid <= 1'b0;
      done <= 1'b0;
    end else begin
      ctl_e.valid <= ctl_in.valid;
      ctl_s.valid <= ctl_e.valid;
      ctl_h.valid <= ctl_s.valid;
      done <= ctl_h.valid;
    end
  end

  // error, square and scale stages
  always_ff @(posedge clk) begin
    ctl_e.degen <= ctl_in.degen;
    ex <= ex_next;
    ey <= ey_next;
    ctl_s.degen <= ctl_e.degen;
    sx <= ex * ex;
    sy <= ey * ey;
    ctl_h.degen <= ctl_s.degen;
    res_h <= ctl_s.degen ? RES_MAX : res_sh;
    sat_h <= ctl_s.degen | sat_sh;
  end

  assign sum = sx + sy;

  // rescale to Q.8 with saturation
  if (SH >= 0) begin : g_shr
    logic [SQ_W-1:0] shifted;
    assign shifted = sum >> SH;
    assign sat_sh = |shifted[SQ_W-1:RES_W];
    assign res_sh = sat_sh ? RES_MAX : shifted[RES_W-1:0];
  end else begin : g_shl
    localparam int SHL = -SH;
    logic [SQ_W-1:0] shifted;
    assign shifted = sum << SHL;
    assign sat_sh = sum > (SQ_W'(RES_MAX) >> SHL);
    assign res_sh = sat_sh ? RES_MAX : shifted[RES_W-1:0];
  end

  // output register with threshold clamp
  always_ff @(posedge clk) begin
    degenerate <= ctl_h.degen;
    if (trunc && (sat_h || res_h >= thr)) begin
      residual <= thr;
      clipped <= 1'b1;
    end else begin
      residual <= res_h;
      clipped <= sat_h;
    end
  end

endmodule

FILE: rtl/homography_truncated_residual.sv
// top level of the truncated homography reprojection residual
`timescale 1ns / 1ps
// Scores one point match per clock: start with busy low transfers a match, and
// its result appears on residual, clipped and degenerate for exactly one cycle
// with done high, in order. The receiver cannot stall; busy is high only during
// reset. A match passes through three warp stages, the divider, which resolves
// one quotient bit per stage over 38 + COORD_FRAC_BITS stages, and four scoring
// stages. The user must write registers through cfg_we, cfg_index and cfg_data
// only while no match is in flight; the block itself does not enforce this.
module homography_truncated_residual #(
  parameter int COORD_FRAC_BITS = htr_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [htr_pkg::COORD_W-1:0] prev_x,
  input  logic [htr_pkg::COORD_W-1:0] prev_y,
  input  logic [htr_pkg::COORD_W-1:0] curr_x,
  input  logic [htr_pkg::COORD_W-1:0] curr_y,
  input  logic cfg_we,
  input  logic [htr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [htr_pkg::ROW_W-1:0] cfg_data,
  output logic done,
  output logic [htr_pkg::RES_W-1:0] residual,
  output logic clipped,
  output logic degenerate
);
  import htr_pkg::*;
  `include "homography_truncated_residual_macros.svh"

  localparam int QW = MAG_W + COORD_FRAC_BITS;
  localparam int LAT = QW + 7;

  logic [ROW_W-1:0] coeff_row0, coeff_row1, coeff_row2;
  logic [RES_W-1:0] clamp_threshold;
  logic truncate_enable;
  logic accept;
  ctl_t w_ctl, d_ctl;
  logic w_neg_x, w_neg_y, d_neg_x, d_neg_y, dy_valid;
  logic [QW-1:0] w_dvd_x, w_dvd_y, qx, qy;
  logic [MAG_W-1:0] w_dsr;
  logic [COORD_W-1:0] w_cur_x, w_cur_y, d_cur_x, d_cur_y;

  assign busy = rst;
  assign accept = start & ~busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_row0 <= ROW0_RESET;
      coeff_row1 <= ROW1_RESET;
      coeff_row2 <= ROW2_RESET;
      clamp_threshold <= THRESHOLD_RESET;
      truncate_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEFF_ROW0: coeff_row0 <= cfg_data;
        REG_COEFF_ROW1: coeff_row1 <= cfg_data;
        REG_COEFF_ROW2: coeff_row2 <= cfg_data;
        REG_CLAMP_THRESHOLD: clamp_threshold <= cfg_data[RES_W-1:0];
        REG_TRUNCATE_ENABLE: truncate_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // warp front end
  htr_warp #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .QW(QW)) u_warp (
    .clk(clk), .rst(rst), .in_valid(accept),
    .prev_x(prev_x), .prev_y(prev_y), .curr_x(curr_x), .curr_y(curr_y),
    .row0(coeff_row0), .row1(coeff_row1), .row2(coeff_row2),
    .ctl(w_ctl), .neg_x(w_neg_x), .neg_y(w_neg_y),
    .dvd_x(w_dvd_x), .dvd_y(w_dvd_y), .dsr(w_dsr),
    .cur_x(w_cur_x), .cur_y(w_cur_y)
  );

  // column quotient carries the match control
  htr_div #(.QW(QW), .DB(MAG_W), .TAG_W(COORD_W + 2)) u_div_x (
    .clk(clk), .rst(rst), .in_valid(w_ctl.valid),
    .dividend(w_dvd_x), .divisor(w_dsr), .tag_in({w_neg_x, w_ctl.degen, w_cur_x}),
    .out_valid(d_ctl.valid), .quotient(qx), .tag_out({d_neg_x, d_ctl.degen, d_cur_x})
  );

  // row quotient
  htr_div #(.QW(QW), .DB(MAG_W), .TAG_W(COORD_W + 1)) u_div_y (
    .clk(clk), .rst(rst), .in_valid(w_ctl.valid),
    .dividend(w_dvd_y), .divisor(w_dsr), .tag_in({w_neg_y, w_cur_y}),
    .out_valid(dy_valid), .quotient(qy), .tag_out({d_neg_y, d_cur_y})
  );

  // error scoring back end
  htr_score #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .QW(QW)) u_score (
    .clk(clk), .rst(rst), .ctl_in(d_ctl), .qx(qx), .qy(qy),
    .neg_x(d_neg_x), .neg_y(d_neg_y), .cur_x(d_cur_x), .cur_y(d_cur_y),
    .thr(clamp_threshold), .trunc(truncate_enable),
    .done(done), .residual(residual), .clipped(clipped), .degenerate(degenerate)
  );

  // checks
  `HTR_ASSERT_IMPL(a_lanes_aligned, clk, rst, d_ctl.valid != dy_valid, 1'b0, "divider lanes out of step")
  `HTR_ASSERT_IMPL(a_degen_clips, clk, rst, done && degenerate, clipped, "degenerate result not clipped")
  `HTR_ASSERT_IMPL(a_trunc_bound, clk, rst, done && truncate_enable && !clipped, residual < clamp_threshold, "unclipped residual over threshold")
  `HTR_ASSERT_DELAY(a_latency, clk, rst, accept, LAT, done, "result missing after fixed latency")

endmodule

FILE: sim/testbench.sv
// self-checking testbench for the truncated homography reprojection residual
`timescale 1ns / 1ps
module testbench;
  import htr_pkg::*;

  localparam int FRAC = DEF_COORD_FRAC_BITS;
  localparam int LATENCY = 45 + FRAC;
  localparam int SETTLE = LATENCY + 10;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_SHOWN = 10;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 100;
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_IDX = 3'd5;
  localparam longint unsigned ERR_CAP = 64'h8000_0000;

  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } match_t;

  typedef struct packed {
    logic [RES_W-1:0] res;
    logic clip;
    logic degen;
  } score_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [COORD_W-1:0] prev_x = '0, prev_y = '0, curr_x = '0, curr_y = '0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_COEFF_ROW0;
  logic [ROW_W-1:0] cfg_data = '0;
  logic done;
  logic [RES_W-1:0] residual;
  logic clipped;
  logic degenerate;

  // shadow copy of the block's registers
  logic [ROW_W-1:0] h_row0 = ROW0_RESET, h_row1 = ROW1_RESET, h_row2 = ROW2_RESET;
  logic [RES_W-1:0] h_thresh = THRESHOLD_RESET;
  logic h_trunc = 1'b1;

  match_t pending_matches[$];
  score_t expected_scores[$];
  int mismatches = 0;
  int scored = 0;
  int degen_seen = 0;
  int clip_seen = 0;
  int idle_left = 0;
  bit quiet_tail = 0;
  int stall_cycles = 0;

  homography_truncated_residual uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .prev_x(prev_x), .prev_y(prev_y), .curr_x(curr_x), .curr_y(curr_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .residual(residual), .clipped(clipped), .degenerate(degenerate)
  );

  always #5 clk = ~clk;

  function automatic longint coef(logic [ROW_W-1:0] row, int col);
    logic signed [COEF_W-1:0] c;
    c = row[col*COEF_W +: COEF_W];
    return longint'(c);
  endfunction

  function automatic longint warp_dot(logic [ROW_W-1:0] row, logic [COORD_W-1:0] x,
                                      logic [COORD_W-1:0] y);
    return coef(row, 0) * longint'(x) + coef(row, 1) * longint'(y)
         + coef(row, 2) * (longint'(1) << FRAC);
  endfunction

  // magnitude of one coordinate error, capped at 2^31
  function automatic longint unsigned err_mag(longint num, longint den,
                                              logic [COORD_W-1:0] cur);
    longint q, e;
    longint unsigned m;
    q = (num * (longint'(1) << FRAC)) / den;
    e = q - longint'(cur);
    m = e < 0 ? longint'(-e) : e;
    return m > ERR_CAP ? ERR_CAP : m;
  endfunction

  function automatic score_t score_match(match_t m);
    longint den;
    longint unsigned ex, ey, sum;
    int sh;
    score_t r;
    bit sat;
    sat = 0;
    r.degen = 0;
    r.res = '0;
    den = warp_dot(h_row2, m.px, m.py);
    if (den == 0) begin
      r.degen = 1;
      sat = 1;
      r.res = RES_MAX;
    end else begin
      ex = err_mag(warp_dot(h_row0, m.px, m.py), den, m.cx);
      ey = err_mag(warp_dot(h_row1, m.px, m.py), den, m.cy);
      sum = ex * ex + ey * ey;
      sh = 2 * FRAC - RES_FRAC_BITS;
      if (sh >= 0) begin
        sum = sum >> sh;
        if (sum > 64'hFFFF_FFFF) begin
          sat = 1;
          r.res = RES_MAX;
        end else r.res = sum[RES_W-1:0];
      end else begin
        if (sum > (64'hFFFF_FFFF >> (-sh))) begin
          sat = 1;
          r.res = RES_MAX;
        end else r.res = RES_W'(sum << (-sh));
      end
    end
    r.clip = sat;
    if (h_trunc && (sat || r.res >= h_thresh)) begin
      r.res = h_thresh;
      r.clip = 1;
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] pack_row(int c0, int c1, int c2);
    logic [COEF_W-1:0] a, b, c;
    a = c0[COEF_W-1:0];
    b = c1[COEF_W-1:0];
    c = c2[COEF_W-1:0];
    return {c, b, a};
  endfunction

  // driver: start stays up until the block takes the match
  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
    end else begin
      if (start && !busy) begin
        expected_scores.insert(expected_scores.size(),
                               score_match({prev_x, prev_y, curr_x, curr_y}));
      end
      if (start && busy) begin
        start <= 1;
      end else if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        idle_left <= $urandom_range(1, 16) - 1;
        start <= 0;
      end else if (pending_matches.size() > 0) begin
        match_t m;
        m = pending_matches.pop_front();
        prev_x <= m.px;
        prev_y <= m.py;
        curr_x <= m.cx;
        curr_y <= m.cy;
        start <= 1;
      end else begin
        start <= 0;
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: residual=%h clipped=%b degenerate=%b",
                   residual, clipped, degenerate);
      end else begin
        score_t e;
        e = expected_scores.pop_front();
        scored++;
        if (degenerate) degen_seen++;
        if (clipped) clip_seen++;
        if (residual !== e.res || clipped !== e.clip || degenerate !== e.degen) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("mismatch: residual=%h/%h clipped=%b/%b degenerate=%b/%b (got/exp)",
                     residual, e.res, clipped, e.clip, degenerate, e.degen);
        end
      end
    end
  end

  // watchdog: stalled while work is outstanding
  always @(posedge clk) begin
    if (!rst && (pending_matches.size() > 0 || expected_scores.size() > 0)
        && !(start && !busy) && !done) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("homography_truncated_residual verification failed");
        $finish;
      end
    end else begin
      stall_cycles <= 0;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_COEFF_ROW0: h_row0 = val;
      REG_COEFF_ROW1: h_row1 = val;
      REG_COEFF_ROW2: h_row2 = val;
      REG_CLAMP_THRESHOLD: h_thresh = val[RES_W-1:0];
      REG_TRUNCATE_ENABLE: h_trunc = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    while (pending_matches.size() > 0 || expected_scores.size() > 0 || start)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_match(int px, int py, int cx, int cy);
    match_t m;
    m.px = px[15:0];
    m.py = py[15:0];
    m.cx = cx[15:0];
    m.cy = cy[15:0];
    pending_matches.insert(pending_matches.size(), m);
  endtask

  // mostly matches within 128 of the previous point's coordinates, some fully random
  task automatic add_random_match();
    int px, py;
    px = $urandom_range(0, 16'hFFFF);
    py = $urandom_range(0, 16'hFFFF);
    if ($urandom_range(0, 9) < 7)
      add_match(px, py, px + $urandom_range(0, 256) - 128, py + $urandom_range(0, 256) - 128);
    else
      add_match(px, py, $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
  endtask

  function automatic int jitter(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  initial begin
    int unit;
    unit = 1 << 16;
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed, reset identity homography with the default clamp
    add_match(0, 0, 0, 0);
    add_match(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_match(0, 0, 16'hFFFF, 16'hFFFF);
    add_match(16'hFFFF, 0, 0, 16'hFFFF);
    add_match(100, 100, 150, 100);
    add_match(0, 0, 80, 0);
    add_match(0, 0, 79, 0);
    add_match(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
    drain();

    // plain saturation, no clamp
    write_reg(REG_TRUNCATE_ENABLE, 0);
    write_reg(UNUSED_REG_IDX, '1);
    add_match(0, 0, 16'hFFFF, 16'hFFFF);
    add_match(0, 0, 80, 0);
    add_match(16'h1234, 16'h4321, 16'h1200, 16'h4300);
    drain();

    // zero denominator in both modes
    write_reg(REG_COEFF_ROW2, '0);
    add_match(5, 6, 7, 8);
    add_match(16'hFFFF, 0, 0, 0);
    drain();
    write_reg(REG_TRUNCATE_ENABLE, 1);
    write_reg(REG_CLAMP_THRESHOLD, ROW_W'(32'hFFFF_FFFF));
    add_match(1, 2, 3, 4);
    drain();

    // denominator zero only on the diagonal, extreme gain and error cap
    write_reg(REG_COEFF_ROW2, pack_row(1, -1, 0));
    write_reg(REG_COEFF_ROW0, pack_row(20'hFFFFF, -(1 << 20), 20'hFFFFF));
    write_reg(REG_COEFF_ROW1, pack_row(-(1 << 20), 20'hFFFFF, -(1 << 20)));
    add_match(777, 777, 0, 0);
    add_match(16'hFFFF, 0, 0, 0);
    add_match(0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_match(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    drain();
    write_reg(REG_CLAMP_THRESHOLD, 0);
    add_match(3, 3, 0, 0);
    add_match(0, 0, 0, 0);
    add_match(16'h4000, 16'h0001, 16'h0100, 16'h0200);
    drain();

    // random phases with varied homographies and thresholds
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p % 3 == 2) begin
        write_reg(REG_COEFF_ROW0, ROW_W'({$urandom, $urandom}));
        write_reg(REG_COEFF_ROW1, ROW_W'({$urandom, $urandom}));
        write_reg(REG_COEFF_ROW2, ROW_W'({$urandom, $urandom}));
      end else begin
        write_reg(REG_COEFF_ROW0, pack_row(unit + jitter(2000), jitter(2000), jitter(4000)));
        write_reg(REG_COEFF_ROW1, pack_row(jitter(2000), unit + jitter(2000), jitter(4000)));
        write_reg(REG_COEFF_ROW2, pack_row(jitter(3), jitter(3), unit + jitter(500)));
      end
      write_reg(REG_CLAMP_THRESHOLD,
                ROW_W'(p == 0 ? 32'hFFFF_FFFF
                              : $urandom_range(0, 1 << ($urandom_range(4, 31)))));
      write_reg(REG_TRUNCATE_ENABLE, ROW_W'($urandom_range(0, 1)));
      if (p == RANDOM_PHASES - 1) quiet_tail = 1;
      repeat (PHASE_ITEMS) add_random_match();
      drain();
    end

    $display("scored %0d point matches over %0d random homography settings", scored,
             RANDOM_PHASES);
    $display("%0d clipped, %0d degenerate, %0d mismatches", clip_seen, degen_seen, mismatches);
    if (mismatches == 0 && expected_scores.size() == 0)
      $display("homography_truncated_residual verification clean");
    else
      $display("homography_truncated_residual verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/htr_pkg.sv
rtl/htr_warp.sv
rtl/htr_div.sv
rtl/htr_score.sv
rtl/homography_truncated_residual.sv
sim/testbench.sv
